@@ src/frid_pkg.sv @@
// Package: shared constants and types for the recent identifier window.
`timescale 1ns / 1ps
package frid_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int SLOT_BITS  = $clog2(SLOT_COUNT);
    localparam int COUNT_BITS = $clog2(SLOT_COUNT + 1);
    localparam int IDENT_BITS = 32;
    localparam int CMD_BITS   = 2;

    localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_LIST   = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd2;

    typedef struct packed {
        logic in_ready;
        logic accept;
        logic list_step;
    } t_ctrl_cmd;

    typedef struct packed {
        logic in_valid;
        logic list_req;
        logic load_ok;
        logic list_final;
    } t_dp_status;

endpackage

@@ src/frid_item_if.sv @@
// Interfaces: input beat channel and result beat channel.
`timescale 1ns / 1ps
interface frid_item_if;
    logic                            valid;
    logic                            ready;
    logic [frid_pkg::CMD_BITS-1:0]   command;
    logic [frid_pkg::IDENT_BITS-1:0] ident;

    modport source (output valid, output command, output ident, input ready);
    modport sink   (input valid, input command, input ident, output ready);
endinterface

interface frid_result_if;
    logic                            valid;
    logic                            ready;
    logic                            hit;
    logic                            evicted_valid;
    logic [frid_pkg::IDENT_BITS-1:0] evicted_ident;
    logic                            list_valid;
    logic [frid_pkg::IDENT_BITS-1:0] listed_ident;
    logic [frid_pkg::COUNT_BITS-1:0] held_count;
    logic                            last;

    modport source (output valid, output hit, output evicted_valid, output evicted_ident,
                    output list_valid, output listed_ident, output held_count,
                    output last, input ready);
    modport sink   (input valid, input hit, input evicted_valid, input evicted_ident,
                    input list_valid, input listed_ident, input held_count,
                    input last, output ready);
endinterface

@@ src/frid_ctrl.sv @@
// Controller: sequences beat acceptance and list emission.
`timescale 1ns / 1ps
module frid_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  frid_pkg::t_dp_status i_status,
    output frid_pkg::t_ctrl_cmd  o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LIST = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state         = r_state;
        o_cmd.in_ready  = 1'b0;
        o_cmd.accept    = 1'b0;
        o_cmd.list_step = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = i_status.load_ok;
                o_cmd.accept   = i_status.load_ok && i_status.in_valid;
                if (o_cmd.accept && i_status.list_req) begin
                    n_state = ST_LIST;
                end
            end
            ST_LIST: begin
                o_cmd.list_step = i_status.load_ok;
                if (i_status.load_ok && i_status.list_final) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ src/frid_datapath.sv @@
// Datapath: slot registers, parallel match, ring pointers and result register.
`timescale 1ns / 1ps
module frid_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [frid_pkg::COUNT_BITS-1:0]     i_cfg_wdata,
    input  frid_pkg::t_ctrl_cmd                 i_cmd,
    output frid_pkg::t_dp_status                o_status,
    frid_item_if.sink                           i_item,
    frid_result_if.source                       o_result
);

    logic [frid_pkg::IDENT_BITS-1:0] r_slot_ident [frid_pkg::SLOT_COUNT];
    logic [frid_pkg::SLOT_COUNT-1:0] r_slot_valid;
    logic [frid_pkg::SLOT_BITS-1:0]  r_wp;
    logic [frid_pkg::COUNT_BITS-1:0] r_fill;
    logic [frid_pkg::COUNT_BITS-1:0] r_cap_cfg;
    logic [frid_pkg::SLOT_BITS-1:0]  r_lptr;
    logic [frid_pkg::COUNT_BITS-1:0] r_lrem;

    logic                            r_out_valid;
    logic                            r_hit;
    logic                            r_ev_valid;
    logic [frid_pkg::IDENT_BITS-1:0] r_ev_ident;
    logic                            r_list_valid;
    logic [frid_pkg::IDENT_BITS-1:0] r_listed_ident;
    logic [frid_pkg::COUNT_BITS-1:0] r_held;
    logic                            r_last;

    logic [frid_pkg::COUNT_BITS-1:0] cap;
    logic [frid_pkg::COUNT_BITS-1:0] cap_m1;
    logic [frid_pkg::COUNT_BITS-1:0] wp_inc;
    logic [frid_pkg::SLOT_BITS-1:0]  n_wp;
    logic [frid_pkg::SLOT_BITS-1:0]  lptr_start;
    logic [frid_pkg::SLOT_BITS-1:0]  lptr_dec;
    logic [frid_pkg::SLOT_BITS-1:0]  rd_addr;
    logic [frid_pkg::IDENT_BITS-1:0] rd_data;
    logic                            match;
    logic                            full;
    logic                            load_ok;
    logic                            taken;

    always_comb begin
        if (r_cap_cfg == '0) begin
            cap = frid_pkg::COUNT_BITS'(1);
        end else if (r_cap_cfg > frid_pkg::COUNT_BITS'(frid_pkg::SLOT_COUNT)) begin
            cap = frid_pkg::COUNT_BITS'(frid_pkg::SLOT_COUNT);
        end else begin
            cap = r_cap_cfg;
        end
    end

    assign cap_m1     = cap - frid_pkg::COUNT_BITS'(1);
    assign wp_inc     = {1'b0, r_wp} + frid_pkg::COUNT_BITS'(1);
    assign n_wp       = (wp_inc == cap) ? '0 : wp_inc[frid_pkg::SLOT_BITS-1:0];
    assign lptr_start = (r_wp == '0) ? cap_m1[frid_pkg::SLOT_BITS-1:0]
                                     : r_wp - frid_pkg::SLOT_BITS'(1);
    assign lptr_dec   = (r_lptr == '0) ? cap_m1[frid_pkg::SLOT_BITS-1:0]
                                       : r_lptr - frid_pkg::SLOT_BITS'(1);
    assign full       = (r_fill == cap);
    assign rd_addr    = i_cmd.list_step ? r_lptr : r_wp;
    assign rd_data    = r_slot_ident[rd_addr];

    always_comb begin
        match = 1'b0;
        for (int i = 0; i < frid_pkg::SLOT_COUNT; i++) begin
            match = match | (r_slot_valid[i] && (r_slot_ident[i] == i_item.ident));
        end
    end

    assign load_ok = !r_out_valid || o_result.ready;
    assign taken   = r_out_valid && o_result.ready;

    assign o_status.in_valid   = i_item.valid;
    assign o_status.list_req   = (i_item.command == frid_pkg::CMD_LIST) && (r_fill != '0);
    assign o_status.load_ok    = load_ok;
    assign o_status.list_final = (r_lrem == frid_pkg::COUNT_BITS'(1));

    assign i_item.ready = i_cmd.in_ready;

    // window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
            r_wp         <= '0;
            r_fill       <= '0;
            r_cap_cfg    <= frid_pkg::COUNT_BITS'(frid_pkg::SLOT_COUNT);
            r_lptr       <= '0;
            r_lrem       <= '0;
        end else if (i_cfg_we) begin
            r_cap_cfg    <= i_cfg_wdata;
            r_slot_valid <= '0;
            r_wp         <= '0;
            r_fill       <= '0;
        end else if (i_cmd.accept) begin
            unique case (i_item.command)
                frid_pkg::CMD_INSERT: begin
                    if (!match) begin
                        r_slot_valid[r_wp] <= 1'b1;
                        r_wp               <= n_wp;
                        if (!full) begin
                            r_fill <= r_fill + frid_pkg::COUNT_BITS'(1);
                        end
                    end
                end
                frid_pkg::CMD_LIST: begin
                    r_lptr <= lptr_start;
                    r_lrem <= r_fill;
                end
                frid_pkg::CMD_CLEAR: begin
                    r_slot_valid <= '0;
                    r_wp         <= '0;
                    r_fill       <= '0;
                end
                default: ;
            endcase
        end else if (i_cmd.list_step) begin
            r_lptr <= lptr_dec;
            r_lrem <= r_lrem - frid_pkg::COUNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (i_item.command == frid_pkg::CMD_INSERT) && !match) begin
            r_slot_ident[r_wp] <= i_item.ident;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.accept && !o_status.list_req) || i_cmd.list_step) begin
            r_out_valid <= 1'b1;
        end else if (taken) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.list_step) begin
            r_hit          <= 1'b0;
            r_ev_valid     <= 1'b0;
            r_ev_ident     <= '0;
            r_list_valid   <= 1'b1;
            r_listed_ident <= rd_data;
            r_held         <= r_fill;
            r_last         <= o_status.list_final;
        end else if (i_cmd.accept) begin
            r_hit          <= 1'b0;
            r_ev_valid     <= 1'b0;
            r_ev_ident     <= '0;
            r_list_valid   <= 1'b0;
            r_listed_ident <= '0;
            r_held         <= r_fill;
            r_last         <= 1'b1;
            unique case (i_item.command)
                frid_pkg::CMD_INSERT: begin
                    if (match) begin
                        r_hit <= 1'b1;
                    end else if (full) begin
                        r_ev_valid <= 1'b1;
                        r_ev_ident <= rd_data;
                    end else begin
                        r_held <= r_fill + frid_pkg::COUNT_BITS'(1);
                    end
                end
                frid_pkg::CMD_CLEAR: r_held <= '0;
                default: ;
            endcase
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.hit           = r_hit;
    assign o_result.evicted_valid = r_ev_valid;
    assign o_result.evicted_ident = r_ev_ident;
    assign o_result.list_valid    = r_list_valid;
    assign o_result.listed_ident  = r_listed_ident;
    assign o_result.held_count    = r_held;
    assign o_result.last          = r_last;

endmodule

@@ src/fifo_recent_id_window.sv @@
// Top level: recent identifier window with first-in-first-out replacement.
`timescale 1ns / 1ps
// An insert, clear or idle-code beat produces one result beat; the identifier
// is matched against all sixteen slots in parallel in the accept cycle, so
// inserts can follow each other every cycle while results are taken. A list
// beat of a non-empty window occupies the block: it is accepted, then one
// result beat is given per identifier read from the slot register file,
// newest first; no input beat is taken meanwhile.
// Writing the capacity register empties the window.
module fifo_recent_id_window (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [frid_pkg::COUNT_BITS-1:0]     i_cfg_wdata,
    frid_item_if.sink                           i_item,
    frid_result_if.source                       o_result
);

    frid_pkg::t_ctrl_cmd  cmd;
    frid_pkg::t_dp_status status;

    frid_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    frid_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_item      (i_item),
        .o_result    (o_result)
    );

endmodule

@@ tb/sv/fifo_recent_id_window_test.sv @@
// Testbench: directed and random checking of the recent identifier window against a predictor.
`timescale 1ns / 1ps
module fifo_recent_id_window_test;
    import frid_pkg::*;

    localparam logic [CMD_BITS-1:0] CMD_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int POOL_SIZE   = 20;

    typedef struct packed {
        logic                  hit;
        logic                  evicted_valid;
        logic [IDENT_BITS-1:0] evicted_ident;
        logic                  list_valid;
        logic [IDENT_BITS-1:0] listed_ident;
        logic [COUNT_BITS-1:0] held_count;
        logic                  last;
    } window_result_t;

    class window_mirror;
        bit [IDENT_BITS-1:0] slot_id [SLOT_COUNT];
        bit                  slot_on [SLOT_COUNT];
        int unsigned         wr_pos;
        int unsigned         fill;
        bit [COUNT_BITS-1:0] cap_reg;
        window_result_t      pending_results [$];
        int                  errors;

        function new();
            cap_reg = COUNT_BITS'(SLOT_COUNT);
            errors  = 0;
            flush();
        endfunction

        function void flush();
            foreach (slot_on[i]) slot_on[i] = 1'b0;
            wr_pos = 0;
            fill   = 0;
        endfunction

        function int unsigned span();
            if (cap_reg == 0) return 1;
            if (cap_reg > SLOT_COUNT) return SLOT_COUNT;
            return cap_reg;
        endfunction

        function void set_capacity(bit [COUNT_BITS-1:0] value);
            cap_reg = value;
            flush();
        endfunction

        function void post(bit hit, bit ev, bit [IDENT_BITS-1:0] ev_id, bit lv,
                           bit [IDENT_BITS-1:0] l_id, bit fin);
            window_result_t r;
            r.hit           = hit;
            r.evicted_valid = ev;
            r.evicted_ident = ev_id;
            r.list_valid    = lv;
            r.listed_ident  = l_id;
            r.held_count    = fill[COUNT_BITS-1:0];
            r.last          = fin;
            pending_results = {pending_results, r};
        endfunction

        // Expected result beats for one accepted command beat.
        function void take_command(logic [CMD_BITS-1:0] cmd, logic [IDENT_BITS-1:0] id);
            int unsigned         cap;
            int unsigned         n;
            int unsigned         s;
            bit                  ev;
            bit [IDENT_BITS-1:0] ev_id;
            cap   = span();
            ev    = 1'b0;
            ev_id = '0;
            case (cmd)
                CMD_INSERT: begin
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (slot_on[i] && slot_id[i] == id) begin
                            post(1'b1, 1'b0, '0, 1'b0, '0, 1'b1);
                            return;
                        end
                    end
                    if (wr_pos >= cap) wr_pos = 0;
                    if (fill < cap) begin
                        fill++;
                    end else begin
                        ev    = 1'b1;
                        ev_id = slot_id[wr_pos];
                    end
                    slot_id[wr_pos] = id;
                    slot_on[wr_pos] = 1'b1;
                    wr_pos = (wr_pos + 1) % cap;
                    post(1'b0, ev, ev_id, 1'b0, '0, 1'b1);
                end
                CMD_LIST: begin
                    n = (fill > cap) ? cap : fill;
                    if (n == 0) begin
                        post(1'b0, 1'b0, '0, 1'b0, '0, 1'b1);
                    end else begin
                        for (int i = 0; i < n; i++) begin
                            s = (wr_pos % cap + cap - 1 - i) % cap;
                            post(1'b0, 1'b0, '0, 1'b1, slot_id[s], i + 1 == n);
                        end
                    end
                end
                CMD_CLEAR: begin
                    flush();
                    post(1'b0, 1'b0, '0, 1'b0, '0, 1'b1);
                end
                default: begin
                    post(1'b0, 1'b0, '0, 1'b0, '0, 1'b1);
                end
            endcase
        endfunction

        function void compare_field(string name, logic [IDENT_BITS-1:0] want,
                                    logic [IDENT_BITS-1:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
            end
        endfunction

        function void match_result(window_result_t got);
            window_result_t want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result beat with none expected, actual %h", $time, got);
                return;
            end
            want = pending_results.pop_front();
            compare_field("hit", want.hit, got.hit);
            compare_field("evicted_valid", want.evicted_valid, got.evicted_valid);
            compare_field("evicted_ident", want.evicted_ident, got.evicted_ident);
            compare_field("list_valid", want.list_valid, got.list_valid);
            compare_field("listed_ident", want.listed_ident, got.listed_ident);
            compare_field("held_count", want.held_count, got.held_count);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [COUNT_BITS-1:0] i_cfg_wdata;

    frid_item_if   item_ch ();
    frid_result_if result_ch ();

    window_mirror        mirror;
    bit                  gaps_on = 1'b1;
    bit [IDENT_BITS-1:0] id_pool [POOL_SIZE];
    int unsigned         cycle_count = 0;

    fifo_recent_id_window uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (item_ch),
        .o_result    (result_ch)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("fifo_recent_id_window_test: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        window_result_t seen;
        if (i_rst_n && item_ch.valid && item_ch.ready) begin
            mirror.take_command(item_ch.command, item_ch.ident);
        end
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            seen.hit           = result_ch.hit;
            seen.evicted_valid = result_ch.evicted_valid;
            seen.evicted_ident = result_ch.evicted_ident;
            seen.list_valid    = result_ch.list_valid;
            seen.listed_ident  = result_ch.listed_ident;
            seen.held_count    = result_ch.held_count;
            seen.last          = result_ch.last;
            mirror.match_result(seen);
        end
    end

    // result side back-pressure
    initial begin
        int unsigned stall;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (gaps_on && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 6);
                result_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_command(logic [CMD_BITS-1:0] cmd, logic [IDENT_BITS-1:0] id);
        int unsigned gap;
        gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap != 0) begin
            @(negedge i_clk);
            item_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        item_ch.valid   <= 1'b1;
        item_ch.command <= cmd;
        item_ch.ident   <= id;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        item_ch.valid <= 1'b0;
        while (mirror.pending_results.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_capacity(logic [COUNT_BITS-1:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        mirror.set_capacity(value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_mix(int unsigned count);
        int unsigned         pick;
        logic [IDENT_BITS-1:0] id;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            id = ($urandom_range(0, 3) != 0) ? id_pool[$urandom_range(0, POOL_SIZE - 1)]
                                            : $urandom;
            if (pick < 72) send_command(CMD_INSERT, id);
            else if (pick < 86) send_command(CMD_LIST, $urandom);
            else if (pick < 90) send_command(CMD_CLEAR, $urandom);
            else send_command(CMD_SPARE, $urandom);
        end
    endtask

    initial begin
        mirror = new();
        foreach (id_pool[i]) id_pool[i] = $urandom;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        item_ch.valid   = 1'b0;
        item_ch.command = CMD_INSERT;
        item_ch.ident   = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // capacity at its reset value
        send_command(CMD_LIST, '0);
        send_command(CMD_INSERT, '0);
        send_command(CMD_INSERT, '1);
        send_command(CMD_INSERT, '0);
        send_command(CMD_LIST, '0);
        send_command(CMD_SPARE, '1);
        send_command(CMD_CLEAR, '0);
        send_command(CMD_LIST, '0);

        write_capacity(2);
        send_command(CMD_INSERT, 32'h1234_5678);
        send_command(CMD_INSERT, 32'h8765_4321);
        send_command(CMD_INSERT, 32'hA5A5_5A5A);
        send_command(CMD_INSERT, 32'h8765_4321);
        send_command(CMD_LIST, '0);
        send_command(CMD_SPARE, '0);

        // zero behaves as a window of one
        write_capacity(0);
        send_command(CMD_INSERT, 32'd5);
        send_command(CMD_INSERT, 32'd6);
        send_command(CMD_LIST, '0);
        send_command(CMD_CLEAR, '0);
        send_command(CMD_LIST, '0);

        // above the slot count: full window, wraparound and long lists
        write_capacity(31);
        repeat (SLOT_COUNT + 1) send_command(CMD_INSERT, $urandom);
        send_command(CMD_LIST, '0);
        run_mix(12);

        write_capacity(1);
        run_mix(30);

        write_capacity(5);
        run_mix(15);
        drain_results();
        run_mix(15);

        write_capacity(16);
        run_mix(30);

        write_capacity(17);
        run_mix(30);

        write_capacity(0);
        run_mix(15);

        gaps_on = 1'b0;
        write_capacity(3);
        run_mix(30);

        drain_results();
        repeat (10) @(negedge i_clk);
        if (mirror.errors == 0) begin
            $display("fifo_recent_id_window_test: clean");
        end else begin
            $display("fifo_recent_id_window_test: errors");
        end
        $finish;
    end
endmodule
